/* rtl/drbt_pkg.sv */
// shared constants, codes and controller/datapath interface types for the band tracker
`default_nettype none
package drbt_pkg;

	localparam int MAX_BAND_SLOTS = 8;
	localparam int PANEL_ROWS     = 240;

	localparam int ROW_W   = 8;
	localparam int COORD_W = 12;
	localparam int IDX_W   = (MAX_BAND_SLOTS > 1) ? $clog2(MAX_BAND_SLOTS) : 1;
	localparam int CNT_W   = $clog2(MAX_BAND_SLOTS + 1);

	localparam logic [ROW_W-1:0]          PANEL_LAST   = ROW_W'(PANEL_ROWS - 1);
	localparam logic signed [COORD_W-1:0] PANEL_ROWS_S = $signed(COORD_W'(PANEL_ROWS));
	localparam logic signed [COORD_W-1:0] PANEL_LAST_S = $signed(COORD_W'(PANEL_ROWS - 1));
	localparam logic [CNT_W-1:0]          SLOTS_CNT    = CNT_W'(MAX_BAND_SLOTS);

	typedef enum logic [1:0] {
		FUNC_MARK  = 2'd0,
		FUNC_ALL   = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STAT_IGNORED   = 3'd0,
		STAT_MERGED    = 3'd1,
		STAT_APPENDED  = 3'd2,
		STAT_COLLAPSED = 3'd3,
		STAT_ALL       = 3'd4,
		STAT_CLEARED   = 3'd5,
		STAT_READ      = 3'd6
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_RDWAIT,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_OFFSCREEN,
		OP_MARK_ALL,
		OP_CLEAR,
		OP_READ_ISSUE,
		OP_READ_DONE,
		OP_SCAN_START,
		OP_SCAN_STEP,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   emit;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  offscreen;
		logic  count_zero;
		logic  scan_last;
	} dp_stat_t;

endpackage
`default_nettype wire

/* rtl/drbt_ram.sv */
// generic single write port ram with registered, enabled read
`default_nettype none
module drbt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic                                         re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* rtl/drbt_ctrl.sv */
// sequencer for the band tracker: decodes the item, steps the scan, owns the result handshake
`default_nettype none
module drbt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire drbt_pkg::dp_stat_t stat,
	output drbt_pkg::dp_cmd_t       cmd
);
	import drbt_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.emit = 1'b0;
		// result slot still held by the consumer
		busy     = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				case (stat.func)
					FUNC_MARK: begin
						if (stat.offscreen) begin
							if (!busy) begin
								cmd.op   = OP_OFFSCREEN;
								cmd.emit = 1'b1;
								state_d  = ST_IDLE;
							end
						end else if (stat.count_zero) begin
							state_d = ST_FINISH;
						end else begin
							cmd.op  = OP_SCAN_START;
							state_d = ST_SCAN;
						end
					end
					FUNC_ALL: begin
						if (!busy) begin
							cmd.op   = OP_MARK_ALL;
							cmd.emit = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					FUNC_CLEAR: begin
						if (!busy) begin
							cmd.op   = OP_CLEAR;
							cmd.emit = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					default: begin
						cmd.op  = OP_READ_ISSUE;
						state_d = ST_RDWAIT;
					end
				endcase
			end
			ST_RDWAIT: begin
				if (!busy) begin
					cmd.op   = OP_READ_DONE;
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.op = OP_SCAN_STEP;
				if (stat.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!busy) begin
					cmd.op   = OP_FINISH;
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (cmd.emit) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

/* rtl/drbt_dp.sv */
// band tracker datapath: request clipping, band ram, scan compaction and result registers
`default_nettype none
module drbt_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [1:0]                          func,
	input  wire logic signed [drbt_pkg::COORD_W-1:0] first_row,
	input  wire logic signed [drbt_pkg::COORD_W-1:0] last_row,
	input  wire logic [2:0]                          band_index,
	input  wire drbt_pkg::dp_cmd_t                   cmd,
	output drbt_pkg::dp_stat_t                       stat,
	output logic [2:0]                               status,
	output logic [drbt_pkg::CNT_W-1:0]               band_count,
	output logic [drbt_pkg::ROW_W-1:0]               band_top,
	output logic [drbt_pkg::ROW_W-1:0]               band_bottom,
	output logic                                     band_valid
);
	import drbt_pkg::*;

	// request held for the whole item
	func_t              func_q;
	logic [ROW_W-1:0]   lo_q, hi_q;
	logic               offscr_q;
	logic [IDX_W-1:0]   idx_q;

	// band state and scan bookkeeping
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   rd_ptr_q, wr_ptr_q;
	logic               found_q;
	logic [IDX_W-1:0]   pos_q;
	logic [ROW_W-1:0]   acc_t_lo_q, acc_t_hi_q, acc_a_lo_q, acc_a_hi_q;

	// result registers
	logic [2:0]         status_q;
	logic [CNT_W-1:0]   count_out_q;
	logic [ROW_W-1:0]   top_q, bottom_q;
	logic               valid_q;

	// load path
	logic signed [COORD_W-1:0] mn_s, mx_s;
	logic                      offscr_c;
	logic [ROW_W-1:0]          lo_c, hi_c;

	// ram ports
	logic                 we, re;
	logic [IDX_W-1:0]     waddr, raddr;
	logic [2*ROW_W-1:0]   wdata, rdata;

	logic [ROW_W-1:0] ent_first, ent_last;
	logic             touch;
	logic             rd_ok;
	stat_t            st_d;

	drbt_ram #(
		.WIDTH(2*ROW_W),
		.DEPTH(MAX_BAND_SLOTS)
	) u_band_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// order, reject and clip the incoming span
	always_comb begin
		mn_s     = (first_row < last_row) ? first_row : last_row;
		mx_s     = (first_row < last_row) ? last_row : first_row;
		offscr_c = (mx_s < $signed(COORD_W'(0))) || (mn_s >= PANEL_ROWS_S);
		lo_c     = (mn_s < $signed(COORD_W'(0))) ? '0 : mn_s[ROW_W-1:0];
		hi_c     = (mx_s > PANEL_LAST_S) ? PANEL_LAST : mx_s[ROW_W-1:0];
	end

	assign ent_first = rdata[2*ROW_W-1:ROW_W];
	assign ent_last  = rdata[ROW_W-1:0];

	// overlap or adjacency with the band widened by one row each side
	assign touch = ({1'b0, lo_q} <= ({1'b0, ent_last} + (ROW_W+1)'(1))) &&
	               (({1'b0, hi_q} + (ROW_W+1)'(1)) >= {1'b0, ent_first});

	assign rd_ok = (CNT_W'(idx_q) < count_q);

	always_comb begin
		we      = 1'b0;
		waddr   = wr_ptr_q[IDX_W-1:0];
		wdata   = rdata;
		count_d = count_q;
		re      = 1'b0;
		raddr   = rd_ptr_q[IDX_W-1:0];
		st_d    = STAT_READ;
		case (cmd.op)
			OP_OFFSCREEN: begin
				st_d = STAT_IGNORED;
			end
			OP_MARK_ALL: begin
				we      = 1'b1;
				waddr   = '0;
				wdata   = {ROW_W'(0), PANEL_LAST};
				count_d = CNT_W'(1);
				st_d    = STAT_ALL;
			end
			OP_CLEAR: begin
				count_d = '0;
				st_d    = STAT_CLEARED;
			end
			OP_READ_ISSUE: begin
				re    = 1'b1;
				raddr = idx_q;
			end
			OP_SCAN_START: begin
				re    = 1'b1;
				raddr = '0;
			end
			OP_SCAN_STEP: begin
				re = 1'b1;
				// untouched bands slide down to the write pointer
				we = !touch;
			end
			OP_FINISH: begin
				we = 1'b1;
				if (found_q) begin
					waddr   = pos_q;
					wdata   = {acc_t_lo_q, acc_t_hi_q};
					count_d = wr_ptr_q;
					st_d    = STAT_MERGED;
				end else if (count_q < SLOTS_CNT) begin
					waddr   = count_q[IDX_W-1:0];
					wdata   = {lo_q, hi_q};
					count_d = count_q + CNT_W'(1);
					st_d    = STAT_APPENDED;
				end else begin
					waddr   = '0;
					wdata   = {acc_a_lo_q, acc_a_hi_q};
					count_d = CNT_W'(1);
					st_d    = STAT_COLLAPSED;
				end
			end
			default: begin
				st_d = STAT_READ;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q     <= func_t'(func);
				lo_q       <= lo_c;
				hi_q       <= hi_c;
				offscr_q   <= offscr_c;
				idx_q      <= band_index[IDX_W-1:0];
				rd_ptr_q   <= CNT_W'(1);
				wr_ptr_q   <= '0;
				found_q    <= 1'b0;
				pos_q      <= '0;
				acc_t_lo_q <= lo_c;
				acc_t_hi_q <= hi_c;
				acc_a_lo_q <= lo_c;
				acc_a_hi_q <= hi_c;
			end
			OP_SCAN_STEP: begin
				rd_ptr_q <= rd_ptr_q + CNT_W'(1);
				if (ent_first < acc_a_lo_q) begin
					acc_a_lo_q <= ent_first;
				end
				if (ent_last > acc_a_hi_q) begin
					acc_a_hi_q <= ent_last;
				end
				if (touch) begin
					if (ent_first < acc_t_lo_q) begin
						acc_t_lo_q <= ent_first;
					end
					if (ent_last > acc_t_hi_q) begin
						acc_t_hi_q <= ent_last;
					end
					if (!found_q) begin
						// first touching band keeps its slot for the merged band
						found_q  <= 1'b1;
						pos_q    <= wr_ptr_q[IDX_W-1:0];
						wr_ptr_q <= wr_ptr_q + CNT_W'(1);
					end
				end else begin
					wr_ptr_q <= wr_ptr_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase

		if (cmd.emit) begin
			status_q    <= st_d;
			count_out_q <= count_d;
			if (cmd.op == OP_READ_DONE && rd_ok) begin
				top_q    <= ent_first;
				bottom_q <= ent_last;
				valid_q  <= 1'b1;
			end else begin
				top_q    <= '0;
				bottom_q <= '0;
				valid_q  <= 1'b0;
			end
		end
	end

	assign stat.func       = func_q;
	assign stat.offscreen  = offscr_q;
	assign stat.count_zero = (count_q == '0);
	assign stat.scan_last  = (rd_ptr_q == count_q);

	assign status      = status_q;
	assign band_count  = count_out_q;
	assign band_top    = top_q;
	assign band_bottom = bottom_q;
	assign band_valid  = valid_q;
endmodule
`default_nettype wire

/* rtl/dirty_row_band_tracker_unit.sv */
// top level of the dirty row band tracker: sequencer plus band datapath
`default_nettype none
// Tracks up to eight disjoint row bands of a 240-row panel that still need
// refresh. Each input item is one operation: mark a span of rows (ends in any
// order, signed, clipped to the panel, ignored when wholly off it), mark the
// whole panel, clear, or read back band band_index. A marked span merges with
// every band it overlaps or touches, in place of the first such band, with
// later bands shifting down; a span touching nothing is appended, and with all
// slots full everything collapses into one band. Exactly one result item comes
// back per input item. Bands live in a small ram with one read and one write
// port, and a mark walks it one entry per cycle. The result sits in an output
// register, so a new item is accepted while the previous result still waits;
// the block only stalls when a fresh result is ready and the old one has not
// been taken. No clearing pass is needed after reset: the pending count starts
// at zero and band entries are only used below it.
module dirty_row_band_tracker_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          func,
	input  wire logic signed [drbt_pkg::COORD_W-1:0] first_row,
	input  wire logic signed [drbt_pkg::COORD_W-1:0] last_row,
	input  wire logic [2:0]                          band_index,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [2:0]                               status,
	output logic [drbt_pkg::CNT_W-1:0]               band_count,
	output logic [drbt_pkg::ROW_W-1:0]               band_top,
	output logic [drbt_pkg::ROW_W-1:0]               band_bottom,
	output logic                                     band_valid
);
	import drbt_pkg::*;

	// command from sequencer, status back from datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	drbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	drbt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.func       (func),
		.first_row  (first_row),
		.last_row   (last_row),
		.band_index (band_index),
		.cmd        (cmd),
		.stat       (stat),
		.status     (status),
		.band_count (band_count),
		.band_top   (band_top),
		.band_bottom(band_bottom),
		.band_valid (band_valid)
	);
endmodule
`default_nettype wire

/* rtl/drbt_checker.sv */
// port-level checks for the band tracker and their bind to the top level
`default_nettype none
module drbt_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic [1:0]                          func,
	input wire logic signed [drbt_pkg::COORD_W-1:0] first_row,
	input wire logic signed [drbt_pkg::COORD_W-1:0] last_row,
	input wire logic [2:0]                          band_index,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [2:0]                          status,
	input wire logic [drbt_pkg::CNT_W-1:0]          band_count,
	input wire logic [drbt_pkg::ROW_W-1:0]          band_top,
	input wire logic [drbt_pkg::ROW_W-1:0]          band_bottom,
	input wire logic                                band_valid
);
	import drbt_pkg::*;

	// a waiting request item keeps its payload until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(func) && $stable(first_row) &&
		$stable(last_row) && $stable(band_index))
		else $error("request changed while waiting");

	// held result stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(band_count) && $stable(band_top) && $stable(band_bottom))
		else $error("result changed while stalled");

	// a valid read shows an ordered band on the panel
	a_band_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && band_valid |-> status == 3'(STAT_READ) &&
		band_top <= band_bottom && band_bottom <= PANEL_LAST &&
		band_count != '0)
		else $error("bad band on read");

	// non-read results carry no band
	a_no_band: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 3'(STAT_READ) |->
		!band_valid && band_top == '0 && band_bottom == '0)
		else $error("band fields set on non-read result");

	// count never exceeds the slot count, and a collapse or mark-all leaves one band
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> band_count <= SLOTS_CNT &&
		((status != 3'(STAT_COLLAPSED) && status != 3'(STAT_ALL)) ||
		band_count == CNT_W'(1)))
		else $error("band count out of range");
endmodule

bind dirty_row_band_tracker_unit drbt_checker u_drbt_checker (.*);
`default_nettype wire

/* bench/band_tracker_checker.sv */
// checker for the row band tracker: mirrors the band list and compares each result item
module band_tracker_checker
	import drbt_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic                      in_ready,
	input  wire logic [1:0]                func,
	input  wire logic signed [COORD_W-1:0] first_row,
	input  wire logic signed [COORD_W-1:0] last_row,
	input  wire logic [2:0]                band_index,
	input  wire logic                      out_valid,
	input  wire logic                      out_ready,
	input  wire logic [2:0]                status,
	input  wire logic [CNT_W-1:0]          band_count,
	input  wire logic [ROW_W-1:0]          band_top,
	input  wire logic [ROW_W-1:0]          band_bottom,
	input  wire logic                      band_valid,
	output int                             mismatches,
	output int                             outstanding
);

	typedef struct packed {
		stat_t             status;
		logic [CNT_W-1:0]  count;
		logic [ROW_W-1:0]  top;
		logic [ROW_W-1:0]  bottom;
		logic              valid;
	} band_result_t;

	logic [ROW_W-1:0] span_first [MAX_BAND_SLOTS];
	logic [ROW_W-1:0] span_last  [MAX_BAND_SLOTS];
	int               spans_held = 0;
	band_result_t     results_due [$];
	int               results_seen = 0;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	// widened by one row on each side, so adjacent spans join
	function automatic bit touches_span(int lo, int hi, int k);
		return lo <= int'(span_last[k]) + 1 && hi >= int'(span_first[k]) - 1;
	endfunction

	function automatic void drop_span(int k);
		int m;
		for (m = k; m < spans_held - 1; m++) begin
			span_first[m] = span_first[m + 1];
			span_last[m]  = span_last[m + 1];
		end
		spans_held--;
	endfunction

	function automatic stat_t mark_span(int lo, int hi);
		int tmp;
		int i;
		int j;
		if (hi < lo) begin
			tmp = lo;
			lo  = hi;
			hi  = tmp;
		end
		if (hi < 0 || lo >= PANEL_ROWS)
			return STAT_IGNORED;
		if (lo < 0)
			lo = 0;
		if (hi > PANEL_ROWS - 1)
			hi = PANEL_ROWS - 1;
		for (i = 0; i < spans_held; i++) begin
			if (touches_span(lo, hi, i)) begin
				if (lo < int'(span_first[i]))
					span_first[i] = ROW_W'(lo);
				if (hi > int'(span_last[i]))
					span_last[i] = ROW_W'(hi);
				// absorb every other band the request touches
				j = 0;
				while (j < spans_held) begin
					if (j != i && touches_span(lo, hi, j)) begin
						if (span_first[j] < span_first[i])
							span_first[i] = span_first[j];
						if (span_last[j] > span_last[i])
							span_last[i] = span_last[j];
						drop_span(j);
						if (j < i)
							i--;
					end else begin
						j++;
					end
				end
				return STAT_MERGED;
			end
		end
		if (spans_held < MAX_BAND_SLOTS) begin
			span_first[spans_held] = ROW_W'(lo);
			span_last[spans_held]  = ROW_W'(hi);
			spans_held++;
			return STAT_APPENDED;
		end
		// no free slot: fold everything into one band
		for (i = 0; i < spans_held; i++) begin
			if (int'(span_first[i]) < lo)
				lo = int'(span_first[i]);
			if (int'(span_last[i]) > hi)
				hi = int'(span_last[i]);
		end
		spans_held    = 1;
		span_first[0] = ROW_W'(lo);
		span_last[0]  = ROW_W'(hi);
		return STAT_COLLAPSED;
	endfunction

	function automatic band_result_t predict_result(func_t op, logic signed [COORD_W-1:0] a,
			logic signed [COORD_W-1:0] b, logic [2:0] idx);
		band_result_t r;
		r = '0;
		case (op)
			FUNC_MARK: begin
				r.status = mark_span(int'(a), int'(b));
			end
			FUNC_ALL: begin
				spans_held    = 1;
				span_first[0] = '0;
				span_last[0]  = PANEL_LAST;
				r.status      = STAT_ALL;
			end
			FUNC_CLEAR: begin
				spans_held = 0;
				r.status   = STAT_CLEARED;
			end
			default: begin
				r.status = STAT_READ;
				if (int'(idx) < spans_held) begin
					r.top    = span_first[idx];
					r.bottom = span_last[idx];
					r.valid  = 1'b1;
				end
			end
		endcase
		r.count = CNT_W'(spans_held);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch
		band_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (results_due.size() == 0) begin
					report_mismatch("result with none pending, status", int'(status), -1);
				end else begin
					want = results_due.pop_front();
					if (status !== want.status)
						report_mismatch("status", int'(status), int'(want.status));
					if (band_count !== want.count)
						report_mismatch("band_count", int'(band_count), int'(want.count));
					if (band_top !== want.top)
						report_mismatch("band_top", int'(band_top), int'(want.top));
					if (band_bottom !== want.bottom)
						report_mismatch("band_bottom", int'(band_bottom), int'(want.bottom));
					if (band_valid !== want.valid)
						report_mismatch("band_valid", int'(band_valid), int'(want.valid));
				end
			end
			if (in_valid && in_ready)
				results_due.push_back(predict_result(func_t'(func), first_row, last_row,
					band_index));
			outstanding = results_due.size();
		end
	end

endmodule

/* bench/tb.sv */
// testbench top for the row band tracker: stimulus, result-side stalls and verdict
module tb;
	import drbt_pkg::*;

	// one item in and one result out per operation; a mark walks the band list
	// before the block takes the next item
	localparam int RANDOM_ITEMS = 650;
	localparam int DRAIN_CYCLES = 24;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                func;
	logic signed [COORD_W-1:0] first_row;
	logic signed [COORD_W-1:0] last_row;
	logic [2:0]                band_index;
	logic                      out_valid;
	logic                      out_ready;
	logic [2:0]                status;
	logic [CNT_W-1:0]          band_count;
	logic [ROW_W-1:0]          band_top;
	logic [ROW_W-1:0]          band_bottom;
	logic                      band_valid;
	int                        mismatches;
	int                        outstanding;
	int                        burst_left = 0;

	dirty_row_band_tracker_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.first_row   (first_row),
		.last_row    (last_row),
		.band_index  (band_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.band_count  (band_count),
		.band_top    (band_top),
		.band_bottom (band_bottom),
		.band_valid  (band_valid)
	);

	// the checker sees both channels and keeps its own copy of the band list
	band_tracker_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.first_row   (first_row),
		.last_row    (last_row),
		.band_index  (band_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.band_count  (band_count),
		.band_top    (band_top),
		.band_bottom (band_bottom),
		.band_valid  (band_valid),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	// result side stalls: each stretch picks a mode, one of them never stalls
	initial begin : result_stalls
		int mode;
		int phase;
		out_ready = 1'b0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(16, 96)) begin
				@(negedge clk);
				phase++;
				case (mode)
					0: out_ready = 1'b1;
					1: out_ready = 1'($urandom_range(0, 1));
					2: out_ready = ($urandom_range(0, 3) == 0);
					default: out_ready = (phase % 3 == 0);
				endcase
			end
		end
	end

	// bursts of back-to-back items split by random idle gaps
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 10);
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	// present one item at the falling edge and hold it until it is taken
	task automatic send_item(func_t op, int a, int b, int idx);
		pace_sender();
		@(negedge clk);
		func       = op;
		first_row  = COORD_W'(a);
		last_row   = COORD_W'(b);
		band_index = 3'(idx);
		in_valid   = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// a mostly in-panel span of random size, sometimes hanging off the top,
	// ends given in either order
	task automatic send_span();
		int lo;
		int hi;
		lo = $urandom_range(0, PANEL_ROWS - 1);
		if ($urandom_range(0, 4) == 0)
			hi = lo + $urandom_range(0, PANEL_ROWS - 1);
		else
			hi = lo + $urandom_range(0, 10);
		if ($urandom_range(0, 15) == 0)
			lo -= $urandom_range(1, 40);
		if ($urandom_range(0, 1) == 1)
			send_item(FUNC_MARK, hi, lo, $urandom_range(0, 7));
		else
			send_item(FUNC_MARK, lo, hi, $urandom_range(0, 7));
	endtask

	initial begin : stimulus
		int n;
		int pick;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		func       = FUNC_MARK;
		first_row  = '0;
		last_row   = '0;
		band_index = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// read with nothing pending, then marks wholly off the panel
		send_item(FUNC_READ, 0, 0, 0);
		send_item(FUNC_MARK, -2048, -1, 7);
		send_item(FUNC_MARK, 2047, PANEL_ROWS, 0);
		// reversed ends get swapped, then two more disjoint bands
		send_item(FUNC_MARK, 10, 5, 0);
		send_item(FUNC_MARK, 20, 25, 0);
		send_item(FUNC_MARK, 30, 35, 0);
		// touching the end of a band grows it
		send_item(FUNC_MARK, 11, 11, 0);
		// one span bridging all three absorbs the later bands
		send_item(FUNC_MARK, 12, 29, 0);
		// fill every slot, then one more mark folds all into one band
		send_item(FUNC_MARK, 50, 52, 0);
		send_item(FUNC_MARK, 60, 62, 0);
		send_item(FUNC_MARK, 80, 80, 0);
		send_item(FUNC_MARK, 100, 104, 0);
		send_item(FUNC_MARK, 120, 121, 0);
		send_item(FUNC_MARK, 140, 150, 0);
		send_item(FUNC_MARK, 160, 170, 0);
		send_item(FUNC_READ, 0, 0, 7);
		send_item(FUNC_MARK, 205, 200, 0);
		send_item(FUNC_READ, 0, 0, 0);
		send_item(FUNC_READ, 0, 0, 7);
		// span clipped at both panel edges
		send_item(FUNC_MARK, -2048, 2047, 0);
		send_item(FUNC_ALL, 2047, -2048, 5);
		send_item(FUNC_READ, -1, -1, 0);
		send_item(FUNC_CLEAR, 0, 0, 0);
		send_item(FUNC_MARK, PANEL_ROWS - 1, PANEL_ROWS - 1, 0);
		send_item(FUNC_READ, 0, 0, 0);

		// random part: mostly well-formed spans and reads, some noise
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_span();
			else if (pick < 62)
				send_item(FUNC_MARK, $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 7));
			else if (pick < 90)
				send_item(FUNC_READ, $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 7));
			else if (pick < 94)
				send_item(FUNC_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 7));
			else if (pick < 97)
				send_item(FUNC_ALL, $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 7));
			else
				send_item(func_t'($urandom_range(0, 3)), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 7));
		end
		@(negedge clk);
		in_valid = 1'b0;

		// drain the results, then give the block time to show anything extra
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
